// ----- rtl/bmpd_pkg.sv -----
`default_nettype none

package bmpd_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	// Result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_NOTICE = 1'b1;

	// Pixel formats
	localparam logic [1:0] FMT_BGRA32 = 2'd0;
	localparam logic [1:0] FMT_BGR24  = 2'd1;
	localparam logic [1:0] FMT_GRAY8  = 2'd2;

	// Header layout: field start positions and fixed header length
	localparam logic [31:0] HDR_LEN    = 32'd54;
	localparam logic [31:0] POS_OFFSET = 32'd10;
	localparam logic [31:0] POS_WIDTH  = 32'd18;
	localparam logic [31:0] POS_HEIGHT = 32'd22;
	localparam logic [31:0] POS_BPP    = 32'd28;

	// Supported depths
	localparam logic [15:0] BPP_8  = 16'd8;
	localparam logic [15:0] BPP_24 = 16'd24;
	localparam logic [15:0] BPP_32 = 16'd32;

	// One result word
	typedef struct packed {
		logic        kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [1:0]  fmt;
		logic [11:0] row;
		logic [11:0] column;
		logic        last;
	} result_t;

	// Bytes per pixel for a depth, 0 when the depth is unsupported
	function automatic logic [2:0] bytes_per_pixel(input logic [15:0] bpp);
		logic [2:0] n;
		n = 3'd0;
		if (bpp == BPP_32) n = 3'd4;
		else if (bpp == BPP_24) n = 3'd3;
		else if (bpp == BPP_8) n = 3'd1;
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bmpd_decode.sv -----
`default_nettype none

module bmpd_decode import bmpd_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	input  wire logic       start_in,
	output logic            has_result,
	output result_t         result
);

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

	// Decoder state
	logic [31:0]   pos_q, off_q, width_q, height_q;
	logic [15:0]   bpp_q;
	logic [1:0]    idx_q, pad_q;
	logic [23:0]   part_q;
	logic [CW-1:0] rows_q, col_q;
	phase_t        phase_q;

	// State seen by this word (reset to its start values by a file start)
	logic [31:0]   pos_e, off_e, width_e, height_e;
	logic [15:0]   bpp_e;
	logic [1:0]    idx_e, pad_e;
	logic [23:0]   part_e;
	logic [CW-1:0] rows_e, col_e;
	phase_t        phase_e;

	// Next state
	logic [31:0]   pos_n, off_n, width_n, height_n;
	logic [15:0]   bpp_n;
	logic [1:0]    idx_n, pad_n;
	logic [23:0]   part_n;
	logic [CW-1:0] rows_n, col_n;
	phase_t        phase_n;

	logic [31:0] eff_off;
	logic        hdr_end;
	logic        hdr_bad;
	logic [2:0]  bpb;
	logic [31:0] rows_w, col_w;
	logic [3:0]  pad_prod;

	// Restart on a file start
	always_comb begin
		if (start_in) begin
			pos_e    = '0;
			off_e    = HDR_LEN;
			width_e  = '0;
			height_e = '0;
			bpp_e    = '0;
			idx_e    = '0;
			part_e   = '0;
			rows_e   = '0;
			col_e    = '0;
			pad_e    = '0;
			phase_e  = PH_HEADER;
		end else begin
			pos_e    = pos_q;
			off_e    = off_q;
			width_e  = width_q;
			height_e = height_q;
			bpp_e    = bpp_q;
			idx_e    = idx_q;
			part_e   = part_q;
			rows_e   = rows_q;
			col_e    = col_q;
			pad_e    = pad_q;
			phase_e  = phase_q;
		end
	end

	assign bpb    = bytes_per_pixel(bpp_e);
	assign rows_w = 32'(rows_e);
	assign col_w  = 32'(col_e);

	// Capture header fields and check the header on its last byte; then unpack pixels
	always_comb begin
		pos_n    = pos_e;
		off_n    = off_e;
		width_n  = width_e;
		height_n = height_e;
		bpp_n    = bpp_e;
		idx_n    = idx_e;
		part_n   = part_e;
		rows_n   = rows_e;
		col_n    = col_e;
		pad_n    = pad_e;
		phase_n  = phase_e;
		has_result = 1'b0;
		result     = '0;
		eff_off  = '0;
		hdr_end  = 1'b0;
		hdr_bad  = 1'b0;
		pad_prod = '0;

		unique case (phase_e)
			PH_HEADER: begin
				case (pos_e)
					POS_OFFSET:          off_n = {24'd0, byte_in};
					POS_OFFSET + 32'd1:  off_n[15:8] = byte_in;
					POS_OFFSET + 32'd2:  off_n[23:16] = byte_in;
					POS_OFFSET + 32'd3:  off_n[31:24] = byte_in;
					POS_WIDTH:           width_n = {24'd0, byte_in};
					POS_WIDTH + 32'd1:   width_n[15:8] = byte_in;
					POS_WIDTH + 32'd2:   width_n[23:16] = byte_in;
					POS_WIDTH + 32'd3:   width_n[31:24] = byte_in;
					POS_HEIGHT:          height_n = {24'd0, byte_in};
					POS_HEIGHT + 32'd1:  height_n[15:8] = byte_in;
					POS_HEIGHT + 32'd2:  height_n[23:16] = byte_in;
					POS_HEIGHT + 32'd3:  height_n[31:24] = byte_in;
					POS_BPP:             bpp_n = {8'd0, byte_in};
					POS_BPP + 32'd1:     bpp_n[15:8] = byte_in;
					default: ;
				endcase
				// An offset inside the fixed header counts as the header length
				eff_off = (off_n < HDR_LEN) ? HDR_LEN : off_n;
				hdr_end = (pos_e >= HDR_LEN - 32'd1) &&
					((33'(pos_e) + 33'd1) >= 33'(eff_off));
				hdr_bad = (bytes_per_pixel(bpp_n) == 3'd0) ||
					(width_n == 32'd0) || (height_n == 32'd0) ||
					(width_n > MAX_DIM_W) || (height_n > MAX_DIM_W);
				if (hdr_end) begin
					if (hdr_bad) begin
						phase_n     = PH_DONE;
						has_result  = 1'b1;
						result.kind = KIND_NOTICE;
					end else begin
						phase_n = PH_PIXELS;
						idx_n   = '0;
						part_n  = '0;
						rows_n  = '0;
						col_n   = '0;
						pad_n   = '0;
					end
				end else begin
					pos_n = pos_e + 32'd1;
				end
			end

			PH_PIXELS: begin
				if (pad_e != 2'd0) begin
					// Drop a row padding byte
					pad_n = pad_e - 2'd1;
				end else if ((3'({1'b0, idx_e}) + 3'd1) < bpb) begin
					// Collect a leading channel byte
					case (idx_e)
						2'd0:    part_n = {16'd0, byte_in};
						2'd1:    part_n[15:8] = byte_in;
						2'd2:    part_n[23:16] = byte_in;
						default: ;
					endcase
					idx_n = idx_e + 2'd1;
				end else begin
					// Complete the pixel and emit it
					has_result  = 1'b1;
					result.kind = KIND_PIXEL;
					if (bpb == 3'd4) begin
						result.blue  = part_e[7:0];
						result.green = part_e[15:8];
						result.red   = part_e[23:16];
						result.alpha = byte_in;
						result.fmt   = FMT_BGRA32;
					end else if (bpb == 3'd3) begin
						result.blue  = part_e[7:0];
						result.green = part_e[15:8];
						result.red   = byte_in;
						result.fmt   = FMT_BGR24;
					end else begin
						result.red = byte_in;
						result.fmt = FMT_GRAY8;
					end
					result.row    = height_e[11:0] - 12'd1 - rows_w[11:0];
					result.column = col_w[11:0];
					result.last   = ((rows_w + 32'd1) == height_e) &&
						((col_w + 32'd1) == width_e);
					idx_n = '0;
					col_n = col_e + CW'(1);
					// Advance to the next row and skip its padding
					if ((col_w + 32'd1) >= width_e) begin
						col_n    = '0;
						rows_n   = rows_e + CW'(1);
						pad_prod = 4'(width_e[1:0] * bpb[1:0]);
						pad_n    = 2'd0 - pad_prod[1:0];
						if ((rows_w + 32'd1) >= height_e) phase_n = PH_DONE;
					end
				end
			end

			PH_DONE: ;

			default: ;
		endcase
	end

	// Hold state until a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			off_q    <= HDR_LEN;
			width_q  <= '0;
			height_q <= '0;
			bpp_q    <= '0;
			idx_q    <= '0;
			part_q   <= '0;
			rows_q   <= '0;
			col_q    <= '0;
			pad_q    <= '0;
			phase_q  <= PH_HEADER;
		end else if (step) begin
			pos_q    <= pos_n;
			off_q    <= off_n;
			width_q  <= width_n;
			height_q <= height_n;
			bpp_q    <= bpp_n;
			idx_q    <= idx_n;
			part_q   <= part_n;
			rows_q   <= rows_n;
			col_q    <= col_n;
			pad_q    <= pad_n;
			phase_q  <= phase_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_pix_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (bytes_per_pixel(bpp_q) != 3'd0))
		else $error("pixel phase entered with unsupported depth");

	a_pix_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |->
		((32'(col_q) < width_q) && (32'(rows_q) < height_q)))
		else $error("pixel position outside image");

	a_pix_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (3'({1'b0, idx_q}) < bytes_per_pixel(bpp_q)))
		else $error("channel index past pixel size");

	a_notice_src: assert property (@(posedge clk) disable iff (!arst_n)
		(has_result && (result.kind == KIND_NOTICE)) |-> (phase_e == PH_HEADER))
		else $error("notice raised outside header");
`endif

endmodule

`default_nettype wire

// ----- rtl/bmp_byte_stream_pixel_decoder_core.sv -----
`default_nettype none

// BMP byte-stream pixel decoder. Feed the file one byte per word; raise
// file_start with byte 0 of each file to restart decoding (after reset the
// first byte counts as byte 0 anyway). The header ends at byte
// max(data offset, 54) - 1; an unsupported depth (not 8, 24 or 32), a zero
// width or height, or a dimension above MAX_DIM (negative height included)
// yields one notice word with result_kind 1 and all other fields 0, and no
// pixels. Otherwise each pixel comes out with bottom-up row and column, row
// padding is skipped, and last_pixel marks the final one; bytes after the
// image or a notice are ignored until the next file_start. The block takes one
// byte per cycle, and stalls come only from out_ready; every byte is decoded
// combinationally between the input register and the result register, and a
// result is held in the result register until out_ready takes it.
module bmp_byte_stream_pixel_decoder_core import bmpd_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        file_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [1:0]       pixel_format,
	output logic [11:0]      row,
	output logic [11:0]      column,
	output logic             last_pixel
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       advance;
	logic       has_result;
	result_t    result;

	// Process the held word when the result slot is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	bmpd_decode #(
		.MAX_DIM(MAX_DIM)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.start_in  (start_s1),
		.has_result(has_result),
		.result    (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_result;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign result_kind  = res_s2.kind;
	assign red          = res_s2.red;
	assign green        = res_s2.green;
	assign blue         = res_s2.blue;
	assign alpha        = res_s2.alpha;
	assign pixel_format = res_s2.fmt;
	assign row          = res_s2.row;
	assign column       = res_s2.column;
	assign last_pixel   = res_s2.last;

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while decode stage is blocked");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> valid_s2)
		else $error("pending result dropped");

	a_advance_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		(has_result && advance) |=> valid_s2)
		else $error("decoded result not registered");
`endif

endmodule

`default_nettype wire
